// ----- hw/rtl/sdps_pkg.sv -----
// ----------------------------------------------------------------------------
// sdps_pkg
// Shared types, constants and the control store of the staggered drive
// power sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdps_pkg;

    // slot and field widths
    localparam int MAX_SLOTS   = 4;
    localparam int PIN_W       = 4;
    localparam int SLOT_W      = 2;
    localparam int COUNT_W     = 3;
    localparam int WALK_W      = 3;
    localparam int TICK_W      = 8;
    localparam int PC_W        = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_TICKS     = 2'd3;

    // configuration reset values
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST   = 3'd4;
    localparam logic [TICK_W-1:0]  SETTLE_TICKS_RST = 8'd7;
    localparam logic [TICK_W-1:0]  POLL_TICKS_RST   = 8'd1;

    typedef logic [PC_W-1:0] t_pc;

    // microcode step addresses
    localparam t_pc STEP_WAIT       = 4'd0;
    localparam t_pc STEP_MON        = 4'd1;
    localparam t_pc STEP_SYNC_CHK   = 4'd2;
    localparam t_pc STEP_SETTLE_CHK = 4'd3;
    localparam t_pc STEP_POLL_CHK   = 4'd4;
    localparam t_pc STEP_WALK_INIT  = 4'd5;
    localparam t_pc STEP_WALK       = 4'd6;
    localparam t_pc STEP_EMIT       = 4'd7;
    localparam t_pc STEP_SYNC       = 4'd8;
    localparam t_pc STEP_SETTLE     = 4'd9;
    localparam t_pc STEP_POLL       = 4'd10;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP       = 3'd0,
        OP_WALK_INIT = 3'd1,
        OP_WALK_STEP = 3'd2,
        OP_SYNC      = 3'd3,
        OP_SETTLE    = 3'd4,
        OP_POLL_DEC  = 3'd5,
        OP_EMIT      = 3'd6
    } t_op;

    // jump conditions
    typedef enum logic [3:0] {
        C_ALWAYS     = 4'd0,
        C_NO_ITEM    = 4'd1,
        C_MON_OFF    = 4'd2,
        C_NOT_SYNCED = 4'd3,
        C_IN_SETTLE  = 4'd4,
        C_POLL_NZ    = 4'd5,
        C_WALK_MORE  = 4'd6,
        C_SETTLE_END = 4'd7,
        C_OUT_FULL   = 4'd8
    } t_cond;

    // one control word
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   tgt_true;
        t_pc   tgt_false;
    } t_uop;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic mon_off;
        logic not_synced;
        logic in_settle;
        logic poll_nz;
        logic walk_more;
        logic settle_end;
        logic out_full;
    } t_status;

    // control store
    function automatic t_uop rom_word(input t_pc pc);
        t_uop w;
        case (pc)
            STEP_WAIT:       w = '{OP_NOP,       C_NO_ITEM,    STEP_WAIT,   STEP_MON};
            STEP_MON:        w = '{OP_NOP,       C_MON_OFF,    STEP_EMIT,   STEP_SYNC_CHK};
            STEP_SYNC_CHK:   w = '{OP_NOP,       C_NOT_SYNCED, STEP_SYNC,   STEP_SETTLE_CHK};
            STEP_SETTLE_CHK: w = '{OP_NOP,       C_IN_SETTLE,  STEP_SETTLE, STEP_POLL_CHK};
            STEP_POLL_CHK:   w = '{OP_NOP,       C_POLL_NZ,    STEP_POLL,   STEP_WALK_INIT};
            STEP_WALK_INIT:  w = '{OP_WALK_INIT, C_ALWAYS,     STEP_WALK,   STEP_WALK};
            STEP_WALK:       w = '{OP_WALK_STEP, C_WALK_MORE,  STEP_WALK,   STEP_EMIT};
            STEP_EMIT:       w = '{OP_EMIT,      C_OUT_FULL,   STEP_EMIT,   STEP_WAIT};
            STEP_SYNC:       w = '{OP_SYNC,      C_ALWAYS,     STEP_EMIT,   STEP_EMIT};
            STEP_SETTLE:     w = '{OP_SETTLE,    C_SETTLE_END, STEP_WALK,   STEP_EMIT};
            STEP_POLL:       w = '{OP_POLL_DEC,  C_ALWAYS,     STEP_EMIT,   STEP_EMIT};
            default:         w = '{OP_NOP,       C_ALWAYS,     STEP_WAIT,   STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sdps_ctrl.sv -----
// ----------------------------------------------------------------------------
// sdps_ctrl
// Step counter and control store: fetches one control word per cycle and
// picks the next step from the selected condition.
// ----------------------------------------------------------------------------
`default_nettype none

module sdps_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire sdps_pkg::t_status i_status,
    output sdps_pkg::t_op          o_op,
    output logic                   o_idle,
    output logic                   o_item_acc
);

    sdps_pkg::t_pc  r_pc;
    sdps_pkg::t_pc  n_pc;
    sdps_pkg::t_uop w_uop;
    logic           w_cond;

    // control word fetch
    assign w_uop      = sdps_pkg::rom_word(r_pc);
    assign o_op       = w_uop.op;
    assign o_idle     = (r_pc == sdps_pkg::STEP_WAIT);
    assign o_item_acc = o_idle && i_in_valid;

    // condition select
    always_comb begin
        case (w_uop.cond)
            sdps_pkg::C_ALWAYS:     w_cond = 1'b1;
            sdps_pkg::C_NO_ITEM:    w_cond = !i_in_valid;
            sdps_pkg::C_MON_OFF:    w_cond = i_status.mon_off;
            sdps_pkg::C_NOT_SYNCED: w_cond = i_status.not_synced;
            sdps_pkg::C_IN_SETTLE:  w_cond = i_status.in_settle;
            sdps_pkg::C_POLL_NZ:    w_cond = i_status.poll_nz;
            sdps_pkg::C_WALK_MORE:  w_cond = i_status.walk_more;
            sdps_pkg::C_SETTLE_END: w_cond = i_status.settle_end;
            sdps_pkg::C_OUT_FULL:   w_cond = i_status.out_full;
            default:                w_cond = 1'b1;
        endcase
    end

    assign n_pc = w_cond ? w_uop.tgt_true : w_uop.tgt_false;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= sdps_pkg::STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // an accepted word always starts the dispatch chain
    a_acc_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_acc |=> (r_pc == sdps_pkg::STEP_MON))
        else $error("accepted word did not enter dispatch");

    // step counter stays inside the program
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= sdps_pkg::STEP_POLL)
        else $error("step counter left the program");

endmodule

`default_nettype wire

// ----- hw/rtl/sdps_dp.sv -----
// ----------------------------------------------------------------------------
// sdps_dp
// Datapath: configuration registers, enable bits, scan and settle state,
// walk index and the result register, driven by one operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdps_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire sdps_pkg::t_op                     i_op,
    input  wire logic                              i_item_acc,
    input  wire logic [sdps_pkg::PIN_W-1:0]        i_presence_pins,
    input  wire logic                              i_cfg_we,
    input  wire logic [sdps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sdps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_out_stall,
    output sdps_pkg::t_status                      o_status,
    output logic                                   o_out_valid,
    output logic [sdps_pkg::PIN_W-1:0]             o_drive_enable,
    output logic                                   o_settling,
    output logic [sdps_pkg::SLOT_W-1:0]            o_active_slot
);

    // configuration
    logic [sdps_pkg::COUNT_W-1:0] r_slot_count;
    logic                         r_monitor_enable;
    logic [sdps_pkg::TICK_W-1:0]  r_settle_ticks;
    logic [sdps_pkg::TICK_W-1:0]  r_poll_ticks;

    // sequencer state
    logic [sdps_pkg::PIN_W-1:0]   r_enable;
    logic                         r_synced;
    logic [sdps_pkg::SLOT_W-1:0]  r_scan_slot;
    logic                         r_in_settle;
    logic [sdps_pkg::TICK_W-1:0]  r_settle_count;
    logic [sdps_pkg::TICK_W-1:0]  r_poll_count;
    logic [sdps_pkg::WALK_W-1:0]  r_walk_idx;
    logic [sdps_pkg::PIN_W-1:0]   r_pres;

    // result register
    logic                         r_out_valid;
    logic [sdps_pkg::PIN_W-1:0]   r_out_enable;
    logic                         r_out_settling;
    logic [sdps_pkg::SLOT_W-1:0]  r_out_slot;

    logic [sdps_pkg::COUNT_W-1:0] w_count;
    logic [sdps_pkg::PIN_W-1:0]   w_cmask;
    logic [sdps_pkg::PIN_W-1:0]   w_scan_hot;
    logic [sdps_pkg::SLOT_W-1:0]  w_lane;
    logic                         w_idx_in;
    logic                         w_want;
    logic                         w_have;
    logic                         w_plug;
    logic                         w_out_full;
    logic [sdps_pkg::TICK_W-1:0]  w_settle_load;
    logic [sdps_pkg::TICK_W-1:0]  w_poll_load;

    // live slot count saturates at the slot limit
    assign w_count = (r_slot_count > sdps_pkg::COUNT_W'(sdps_pkg::MAX_SLOTS))
                   ? sdps_pkg::COUNT_W'(sdps_pkg::MAX_SLOTS) : r_slot_count;

    // monitored lanes and the settling lane
    always_comb begin
        for (int i = 0; i < sdps_pkg::PIN_W; i++) begin
            w_cmask[i]    = (sdps_pkg::COUNT_W'(i) < w_count);
            w_scan_hot[i] = (r_scan_slot == sdps_pkg::SLOT_W'(i));
        end
    end

    // current walk lane
    assign w_lane   = r_walk_idx[sdps_pkg::SLOT_W-1:0];
    assign w_idx_in = (r_walk_idx < w_count);
    assign w_want   = r_pres[w_lane];
    assign w_have   = r_enable[w_lane];
    assign w_plug   = w_idx_in && w_want && !w_have;

    // zero tick settings act as one
    assign w_settle_load = (r_settle_ticks == '0) ? sdps_pkg::TICK_W'(1) : r_settle_ticks;
    assign w_poll_load   = (r_poll_ticks == '0) ? '0 : (r_poll_ticks - sdps_pkg::TICK_W'(1));

    assign w_out_full = r_out_valid && i_out_stall;

    // status to the sequencer
    assign o_status.mon_off    = !r_monitor_enable;
    assign o_status.not_synced = !r_synced;
    assign o_status.in_settle  = r_in_settle;
    assign o_status.poll_nz    = (r_poll_count != '0);
    assign o_status.walk_more  = w_idx_in && !w_plug;
    assign o_status.settle_end = (r_settle_count <= sdps_pkg::TICK_W'(1));
    assign o_status.out_full   = w_out_full;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count     <= sdps_pkg::SLOT_COUNT_RST;
            r_monitor_enable <= 1'b1;
            r_settle_ticks   <= sdps_pkg::SETTLE_TICKS_RST;
            r_poll_ticks     <= sdps_pkg::POLL_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdps_pkg::CFG_SLOT_COUNT:     r_slot_count     <= i_cfg_data[sdps_pkg::COUNT_W-1:0];
                sdps_pkg::CFG_MONITOR_ENABLE: r_monitor_enable <= i_cfg_data[0];
                sdps_pkg::CFG_SETTLE_TICKS:   r_settle_ticks   <= i_cfg_data;
                sdps_pkg::CFG_POLL_TICKS:     r_poll_ticks     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // presence sample of the accepted word
    always_ff @(posedge i_clk) begin
        if (i_item_acc) begin
            r_pres <= i_presence_pins;
        end
    end

    // sequencer state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= '0;
            r_synced       <= 1'b0;
            r_scan_slot    <= '0;
            r_in_settle    <= 1'b0;
            r_settle_count <= '0;
            r_poll_count   <= '0;
            r_walk_idx     <= '0;
        end else begin
            case (i_op)
                sdps_pkg::OP_SYNC: begin
                    r_enable     <= (r_enable & ~w_cmask) | (r_pres & w_cmask);
                    r_synced     <= 1'b1;
                    r_scan_slot  <= '0;
                    r_poll_count <= '0;
                end
                sdps_pkg::OP_SETTLE: begin
                    // drop absent slots other than the settling one
                    r_enable <= r_enable & ~(w_cmask & ~w_scan_hot & ~r_pres);
                    if (o_status.settle_end) begin
                        r_in_settle    <= 1'b0;
                        r_settle_count <= '0;
                        r_walk_idx     <= {1'b0, r_scan_slot} + sdps_pkg::WALK_W'(1);
                    end else begin
                        r_settle_count <= r_settle_count - sdps_pkg::TICK_W'(1);
                    end
                end
                sdps_pkg::OP_POLL_DEC: begin
                    r_poll_count <= r_poll_count - sdps_pkg::TICK_W'(1);
                end
                sdps_pkg::OP_WALK_INIT: begin
                    r_walk_idx <= '0;
                end
                sdps_pkg::OP_WALK_STEP: begin
                    if (!w_idx_in) begin
                        // walk complete
                        r_scan_slot  <= '0;
                        r_poll_count <= w_poll_load;
                    end else if (w_plug) begin
                        r_enable[w_lane] <= 1'b1;
                        r_scan_slot      <= w_lane;
                        r_in_settle      <= 1'b1;
                        r_settle_count   <= w_settle_load;
                    end else begin
                        if (w_have && !w_want) begin
                            r_enable[w_lane] <= 1'b0;
                        end
                        r_walk_idx <= r_walk_idx + sdps_pkg::WALK_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_op == sdps_pkg::OP_EMIT && !w_out_full) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_op == sdps_pkg::OP_EMIT && !w_out_full) begin
            r_out_enable   <= r_enable;
            r_out_settling <= r_in_settle;
            r_out_slot     <= r_scan_slot;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_enable = r_out_enable;
    assign o_settling     = r_out_settling;
    assign o_active_slot  = r_out_slot;

    // walk index never runs past one beyond the last lane
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk_idx <= sdps_pkg::WALK_W'(sdps_pkg::MAX_SLOTS))
        else $error("walk index out of range");

    // a settle period always has ticks left
    a_settle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_settle |-> (r_settle_count != '0))
        else $error("settling with an empty countdown");

    // a new result only comes from the emit step
    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_op == sdps_pkg::OP_EMIT))
        else $error("result loaded outside the emit step");

endmodule

`default_nettype wire

// ----- hw/rtl/staggered_drive_power_sequencer.sv -----
// ----------------------------------------------------------------------------
// staggered_drive_power_sequencer
// Hot-plug drive power sequencer: syncs enables to presence, then walks the
// slots on each poll, powers one new drive at a time and waits for it to
// settle, dropping removed drives as they go.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_presence_pins
//   out      output     o_out_valid / i_out_stall  o_drive_enable, o_settling,
//                                                  o_active_slot
//   cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// a word runs from accept to result through a dispatch chain of up to five
// control steps, then a slot walk of one slot per cycle (up to five steps),
// then one emit step; the next word can be taken in the cycle after it.
// a new word is accepted only while the step counter sits at its wait step;
// the result register lets the next word in while a result is still stalled.
// reset is synchronous and active low and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module staggered_drive_power_sequencer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [sdps_pkg::PIN_W-1:0]        i_presence_pins,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [sdps_pkg::PIN_W-1:0]             o_drive_enable,
    output logic                                   o_settling,
    output logic [sdps_pkg::SLOT_W-1:0]            o_active_slot,
    input  wire logic                              i_cfg_we,
    input  wire logic [sdps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sdps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    sdps_pkg::t_op     w_op;
    sdps_pkg::t_status w_status;
    logic              w_idle;
    logic              w_item_acc;

    // input side stalls while a word is in progress
    assign o_in_stall = !w_idle;

    // sequencer
    sdps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_op       (w_op),
        .o_idle     (w_idle),
        .o_item_acc (w_item_acc)
    );

    // datapath
    sdps_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (w_op),
        .i_item_acc      (w_item_acc),
        .i_presence_pins (i_presence_pins),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .o_drive_enable  (o_drive_enable),
        .o_settling      (o_settling),
        .o_active_slot   (o_active_slot)
    );

endmodule

`default_nettype wire

// ----- tb/staggered_drive_power_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// staggered_drive_power_sequencer_tb
// Self-checking bench for the drive power sequencer. A clocked driver sends
// presence words from a queue in random bursts and updates a behavioral
// model of the sequencer on every accepted word. A clocked monitor compares
// each result word field by field with the oldest predicted status. Register
// settings change between phases while the block is idle, and the receiver
// stalls on its own pattern with long hold-offs to back up the input.
// ----------------------------------------------------------------------------
module staggered_drive_power_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] enable;
        logic       settling;
        logic [1:0] slot;
    } t_drive_status;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } t_stall_mode;

    // dut connections
    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [3:0] in_pins = '0;
    logic       out_stall = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [3:0] o_drive_enable;
    logic       o_settling;
    logic [1:0] o_active_slot;

    // pending presence words and predicted statuses
    logic [3:0]    presence_q[$];
    t_drive_status status_q[$];
    int            mismatches = 0;

    // register shadows
    logic [2:0] reg_slots = sdps_pkg::SLOT_COUNT_RST;
    logic       reg_monitor = 1'b1;
    logic [7:0] reg_settle = sdps_pkg::SETTLE_TICKS_RST;
    logic [7:0] reg_poll = sdps_pkg::POLL_TICKS_RST;

    // sequencer model state
    logic [3:0] pwr_en = '0;
    logic       sync_done = 1'b0;
    logic [1:0] cur_slot = '0;
    logic       settle_active = 1'b0;
    logic [7:0] settle_left = '0;
    logic [7:0] poll_left = '0;

    // idling controls
    int          gap_max = 3;
    t_stall_mode stall_mode = STALL_RANDOM;
    int          burst_left = 0;
    int          gap_left = 0;
    logic        nxt_valid;
    logic        nxt_stall;
    int          words_taken = 0;
    int          hold_left = 0;
    int          stall_phase = 0;

    staggered_drive_power_sequencer dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_presence_pins(in_pins),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_drive_enable (o_drive_enable),
        .o_settling     (o_settling),
        .o_active_slot  (o_active_slot),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // slot walk from a start slot: drop removed drives, stop at the first new one
    function automatic void walk_slots(input int start, input int count,
                                       input logic [3:0] pins);
        for (int i = start; i < count; i++) begin
            if (pwr_en[i] != pins[i]) begin
                if (pins[i]) begin
                    pwr_en[i] = 1'b1;
                    cur_slot = 2'(i);
                    settle_active = 1'b1;
                    settle_left = (reg_settle == 8'd0) ? 8'd1 : reg_settle;
                    return;
                end
                pwr_en[i] = 1'b0;
            end
        end
        cur_slot = '0;
        poll_left = (reg_poll == 8'd0) ? 8'd0 : reg_poll - 8'd1;
    endfunction

    // one tick of the sequencer, returns the status after the update
    function automatic t_drive_status predict_tick(input logic [3:0] pins);
        int count;
        t_drive_status st;
        count = (reg_slots > sdps_pkg::MAX_SLOTS) ? sdps_pkg::MAX_SLOTS : int'(reg_slots);
        if (reg_monitor) begin
            if (!sync_done) begin
                for (int i = 0; i < count; i++)
                    pwr_en[i] = pins[i];
                sync_done = 1'b1;
                cur_slot = '0;
                poll_left = '0;
            end else if (settle_active) begin
                // the settling slot itself is never dropped here
                for (int i = 0; i < count; i++)
                    if (i != int'(cur_slot) && !pins[i])
                        pwr_en[i] = 1'b0;
                if (settle_left <= 8'd1) begin
                    settle_left = '0;
                    settle_active = 1'b0;
                    walk_slots(int'(cur_slot) + 1, count, pins);
                end else begin
                    settle_left--;
                end
            end else if (poll_left != 8'd0) begin
                poll_left--;
            end else begin
                walk_slots(0, count, pins);
            end
        end
        st.enable = pwr_en;
        st.settling = settle_active;
        st.slot = cur_slot;
        return st;
    endfunction

    // input driver: bursts of words with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                status_q.push_back(predict_tick(in_pins));
                void'(presence_q.pop_front());
            end
            if (!(in_valid && o_in_stall)) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (presence_q.size() != 0) begin
                    nxt_valid = 1'b1;
                    in_pins <= presence_q[0];
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end
                in_valid <= nxt_valid;
            end
        end
    end

    // receiver stall pattern, with long hold-offs at two points of the run
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            words_taken++;
            if (words_taken == 400 || words_taken == 1000)
                hold_left = 300;
        end
        stall_phase++;
        if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
        end else begin
            case (stall_mode)
                STALL_RANDOM:   nxt_stall = ($urandom_range(0, 99) < 35);
                STALL_PERIODIC: nxt_stall = ((stall_phase % 7) < 3);
                default:        nxt_stall = 1'b0;
            endcase
        end
        out_stall <= nxt_stall;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (status_q.size() == 0) begin
                $error("result word with no prediction pending");
                mismatches++;
            end else begin
                t_drive_status exp_st;
                exp_st = status_q.pop_front();
                if (o_drive_enable !== exp_st.enable) begin
                    $error("drive_enable: expected %h, got %h", exp_st.enable, o_drive_enable);
                    mismatches++;
                end
                if (o_settling !== exp_st.settling) begin
                    $error("settling: expected %b, got %b", exp_st.settling, o_settling);
                    mismatches++;
                end
                if (o_active_slot !== exp_st.slot) begin
                    $error("active_slot: expected %0d, got %0d", exp_st.slot, o_active_slot);
                    mismatches++;
                end
            end
        end
    end

    task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            sdps_pkg::CFG_SLOT_COUNT:     reg_slots = val[2:0];
            sdps_pkg::CFG_MONITOR_ENABLE: reg_monitor = val[0];
            sdps_pkg::CFG_SETTLE_TICKS:   reg_settle = val;
            sdps_pkg::CFG_POLL_TICKS:     reg_poll = val;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // wait for every word to be sent and checked, then let the block go idle
    task automatic drain();
        while (presence_q.size() != 0 || status_q.size() != 0 || in_valid)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic add_words(input logic [3:0] w0, input logic [3:0] w1);
        presence_q.push_back(w0);
        presence_q.push_back(w1);
    endtask

    // run limit
    initial begin
        #2_000_000;
        $display("staggered_drive_power_sequencer_tb: FAIL");
        $finish;
    end

    initial begin
        logic [2:0] sc;
        logic       mon;
        logic [7:0] st_ticks;
        logic [7:0] pl_ticks;
        logic [3:0] cur_pins;
        int         r;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // monitoring off: sync is deferred and nothing moves
        set_reg(sdps_pkg::CFG_MONITOR_ENABLE, 8'd0);
        add_words(4'b1011, 4'b1111);
        drain();

        // sync, hot-plug, unplug during settle, zero settle and poll ticks
        set_reg(sdps_pkg::CFG_MONITOR_ENABLE, 8'd1);
        set_reg(sdps_pkg::CFG_SETTLE_TICKS, 8'd0);
        set_reg(sdps_pkg::CFG_POLL_TICKS, 8'd0);
        add_words(4'b0101, 4'b0111);
        add_words(4'b0110, 4'b0110);
        add_words(4'b1111, 4'b0000);
        add_words(4'b0000, 4'b0000);
        presence_q.push_back(4'b1000);
        drain();

        // settle on the top slot, then lower the count under it
        set_reg(sdps_pkg::CFG_SETTLE_TICKS, 8'd3);
        add_words(4'b0000, 4'b0000);
        add_words(4'b0000, 4'b1000);
        drain();
        set_reg(sdps_pkg::CFG_SLOT_COUNT, 8'd2);
        add_words(4'b0000, 4'b0000);
        add_words(4'b0000, 4'b0000);
        drain();

        // no slots monitored
        set_reg(sdps_pkg::CFG_SLOT_COUNT, 8'd0);
        add_words(4'b1111, 4'b0000);
        drain();

        // count above the slot limit saturates
        set_reg(sdps_pkg::CFG_SLOT_COUNT, 8'd7);
        add_words(4'b1111, 4'b0110);
        drain();

        // random phases
        cur_pins = 4'($urandom);
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin sc = 3'd4; mon = 1'b1; st_ticks = 8'd255; pl_ticks = 8'd255; end
                1: begin sc = 3'd1; mon = 1'b1; st_ticks = 8'd1;   pl_ticks = 8'd1;   end
                2: begin sc = 3'd4; mon = 1'b0; st_ticks = 8'd0;   pl_ticks = 8'd0;   end
                3: begin sc = 3'd4; mon = 1'b1; st_ticks = 8'd2;   pl_ticks = 8'd0;   end
                default: begin
                    sc = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
                    mon = ($urandom_range(0, 9) != 0);
                    st_ticks = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 4));
                    pl_ticks = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 3));
                end
            endcase
            // unused upper data bits carry noise
            set_reg(sdps_pkg::CFG_SLOT_COUNT, {5'($urandom), sc});
            set_reg(sdps_pkg::CFG_MONITOR_ENABLE, {7'($urandom), mon});
            set_reg(sdps_pkg::CFG_SETTLE_TICKS, st_ticks);
            set_reg(sdps_pkg::CFG_POLL_TICKS, pl_ticks);
            gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 12);
            stall_mode = t_stall_mode'(ph % 3);

            // drives mostly stay put, with single plug or unplug events
            for (int k = 0; k < 108; k++) begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    cur_pins = 4'($urandom);
                else if (r < 45)
                    cur_pins[$urandom_range(0, 3)] ^= 1'b1;
                presence_q.push_back(cur_pins);
            end
            drain();
        end

        if (mismatches == 0 && status_q.size() == 0) begin
            $display("staggered_drive_power_sequencer_tb: PASS");
        end else begin
            $display("staggered_drive_power_sequencer_tb: FAIL");
        end
        $finish;
    end

endmodule
